// ----- hw/rtl/aled_pkg.sv -----
`timescale 1ns / 1ps

package aled_pkg;

    localparam int LED_COUNT_DEF      = 64;
    localparam int PREAMBLE_BYTES_DEF = 120;

    localparam int PRE_W   = 8;
    localparam int COLOR_W = 24;

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_ZERO_SYM   = 2'd1;
    localparam logic [1:0] REG_ONE_SYM    = 2'd2;

    localparam logic [6:0] BRIGHTNESS_RST = 7'd100;
    localparam logic [7:0] ZERO_SYM_RST   = 8'd192;
    localparam logic [7:0] ONE_SYM_RST    = 8'd248;
    localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;

    // floor(x / 100) == (x * SCALE_RECIP) >> SCALE_SHIFT for x < 43690
    localparam logic [14:0] SCALE_RECIP = 15'd20972;
    localparam int          SCALE_SHIFT = 21;

    localparam logic [4:0] BIT_LAST = 5'd23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic scale;
        logic store;
        logic start;
        logic fetch;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_active;
        logic idx_ok;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/addressable_led_spi_encoder_core.sv -----
`timescale 1ns / 1ps

// Addressable LED SPI encoder. Request kinds on s_tuser: 0 stores one LED color
// scaled by the brightness percentage (index at or beyond LED_COUNT dropped),
// 1 starts a frame, 2 asks for the next frame byte on the m_ stream. A frame is
// PREAMBLE_BYTES zero bytes and then green, red, blue of each LED, MSB first,
// one symbol byte per color bit; m_tlast marks the final byte. Set-color and
// start requests during a frame, ticks while idle, and kind 3 are dropped.
// A set-color request goes through two multiplier stages for the brightness
// scaling, then the color store write; a start request is handled without
// leaving the idle state; a tick does a color store read, then an output
// register load, which waits while the output register is still held by the
// sink. The color store is an on-chip memory with one valid flop per LED, so
// it reads as dark right after reset with no clearing pass. Registers on the
// cfg port: 0 brightness percent, 1 zero symbol, 2 one symbol.
module addressable_led_spi_encoder_core #(
    parameter int LED_COUNT      = aled_pkg::LED_COUNT_DEF,
    parameter int PREAMBLE_BYTES = aled_pkg::PREAMBLE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // led_index, red_in, green_in, blue_in
    input  logic [1:0]  s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // spi_byte
    output logic        m_tlast,    // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import aled_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    aled_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    aled_dp #(
        .LED_COUNT      (LED_COUNT),
        .PREAMBLE_BYTES (PREAMBLE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hw/rtl/aled_ctrl.sv -----
`timescale 1ns / 1ps

module aled_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,    // func
    input  aled_pkg::dp_status_t status,
    output aled_pkg::dp_cmd_t    cmd
);
    import aled_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        FUNC_SET: begin
                            if (!status.frame_active && status.idx_ok) begin
                                state_next = ST_SCALE;
                            end
                        end
                        FUNC_TICK: begin
                            if (status.frame_active) begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    case (s_tuser)
                        FUNC_SET:   cmd.capture = !status.frame_active && status.idx_ok;
                        FUNC_START: cmd.start   = !status.frame_active;
                        FUNC_TICK:  cmd.fetch   = status.frame_active;
                        default:    cmd         = '0;
                    endcase
                end
            end
            ST_SCALE: cmd.scale = 1'b1;
            ST_WRITE: cmd.store = 1'b1;
            ST_EMIT:  cmd.emit  = status.out_free;
            default:  cmd       = '0;
        endcase
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit while output register is full");

    a_emit_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> status.frame_active)
        else $error("byte pending outside a frame");

    a_scale_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |=> (state_reg == ST_WRITE))
        else $error("scaling not followed by store write");

endmodule

// ----- hw/rtl/aled_dp.sv -----
`timescale 1ns / 1ps

module aled_dp #(
    parameter int LED_COUNT      = aled_pkg::LED_COUNT_DEF,
    parameter int PREAMBLE_BYTES = aled_pkg::PREAMBLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          s_tdata,   // led_index, red_in, green_in, blue_in
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // spi_byte
    output logic                 m_tlast,   // frame_last
    input  aled_pkg::dp_cmd_t    cmd,
    output aled_pkg::dp_status_t status
);
    import aled_pkg::*;

    localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);
    localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PREAMBLE_BYTES - 1);
    localparam logic             HAS_PRE  = (PREAMBLE_BYTES != 0);

    logic [6:0] bright_reg;
    logic [7:0] zero_sym_reg;
    logic [7:0] one_sym_reg;

    logic [COLOR_W-1:0] mem [LED_COUNT];
    logic [LED_COUNT-1:0] valid_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic               rd_valid_reg;

    logic [LED_W-1:0]  idx_reg;
    logic [14:0]       prod1_reg [3];
    logic [29:0]       prod2_reg [3];
    logic [7:0]        scaled [3];
    logic [8:0]        quot [3];

    logic              active_reg;
    logic              in_pre_reg;
    logic [PRE_W-1:0]  pre_cnt_reg;
    logic [LED_W-1:0]  led_cnt_reg;
    logic [4:0]        bit_cnt_reg;

    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_valid_reg;

    logic [7:0] comp_in [3];
    logic [4:0] bit_sel;
    logic [COLOR_W-1:0] color;
    logic       pos_last;
    logic [7:0] byte_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg   <= BRIGHTNESS_RST;
            zero_sym_reg <= ZERO_SYM_RST;
            one_sym_reg  <= ONE_SYM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BRIGHTNESS: bright_reg   <= cfg_data[6:0];
                REG_ZERO_SYM:   zero_sym_reg <= cfg_data;
                REG_ONE_SYM:    one_sym_reg  <= cfg_data;
                default:        bright_reg   <= bright_reg;
            endcase
        end
    end

    assign status.idx_ok       = {1'b0, s_tdata[7:0]} < 9'(LED_COUNT);
    assign status.frame_active = active_reg;
    assign status.out_free     = !out_valid_reg || m_tready;

    // red, green, blue lanes
    assign comp_in[0] = s_tdata[15:8];
    assign comp_in[1] = s_tdata[23:16];
    assign comp_in[2] = s_tdata[31:24];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg <= s_tdata[LED_W-1:0];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (cmd.capture) begin
                prod1_reg[l] <= 15'(comp_in[l]) * 15'(bright_reg);
            end
            if (cmd.scale) begin
                prod2_reg[l] <= 30'(prod1_reg[l]) * 30'(SCALE_RECIP);
            end
        end
        assign quot[l]   = prod2_reg[l][SCALE_SHIFT+8:SCALE_SHIFT];
        assign scaled[l] = quot[l][8] ? 8'hFF : quot[l][7:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[idx_reg] <= {scaled[1], scaled[0], scaled[2]};
        end
        if (cmd.fetch) begin
            rd_color_reg <= mem[led_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.store) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.fetch) begin
                rd_valid_reg <= valid_reg[led_cnt_reg];
            end
        end
    end

    assign color     = rd_valid_reg ? rd_color_reg : '0;
    assign bit_sel   = BIT_LAST - bit_cnt_reg;
    assign pos_last  = !in_pre_reg && (led_cnt_reg == LED_LAST) && (bit_cnt_reg == BIT_LAST);
    assign byte_next = in_pre_reg ? PREAMBLE_BYTE :
                       (color[bit_sel] ? one_sym_reg : zero_sym_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            in_pre_reg  <= 1'b0;
            pre_cnt_reg <= '0;
            led_cnt_reg <= '0;
            bit_cnt_reg <= '0;
        end else if (cmd.start) begin
            active_reg  <= 1'b1;
            in_pre_reg  <= HAS_PRE;
            pre_cnt_reg <= '0;
            led_cnt_reg <= '0;
            bit_cnt_reg <= '0;
        end else if (cmd.emit) begin
            if (pos_last) begin
                active_reg  <= 1'b0;
                led_cnt_reg <= '0;
                bit_cnt_reg <= '0;
            end else if (in_pre_reg) begin
                pre_cnt_reg <= pre_cnt_reg + 1'b1;
                if (pre_cnt_reg == PRE_LAST) begin
                    in_pre_reg <= 1'b0;
                end
            end else if (bit_cnt_reg == BIT_LAST) begin
                bit_cnt_reg <= '0;
                led_cnt_reg <= led_cnt_reg + 1'b1;
            end else begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= byte_next;
            out_last_reg <= pos_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && pos_last) |=> !active_reg)
        else $error("frame still active after final byte");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (active_reg && led_cnt_reg == '0 && bit_cnt_reg == '0))
        else $error("frame start left stale position");

    a_idle_position: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (led_cnt_reg == '0 && bit_cnt_reg == '0))
        else $error("position not cleared while idle");

endmodule
